### sv/positional_pid_controller_core_defines.svh
// ----------------------------------------------------------------------------
// positional_pid_controller_core_defines.svh
// Assertion macros for the positional PID controller core. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_PID_CONTROLLER_CORE_DEFINES_SVH
`define POSITIONAL_PID_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PPID_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PPID_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPID_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PPID_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### sv/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// Types, register map and shared helpers of the positional PID controller.
// ----------------------------------------------------------------------------
package ppid_pkg;

  // field widths
  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 24;
  localparam int LIM_W      = 31;
  localparam int MODE_W     = 3;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  // mode flag bit positions
  localparam int MODE_ERR_CLAMP = 0;
  localparam int MODE_SEP       = 1;
  localparam int MODE_INT_CLAMP = 2;

  // register reset values
  localparam logic [GAIN_W-1:0] KP_RESET     = 24'd65536;
  localparam logic [GAIN_W-1:0] KI_RESET     = 24'd0;
  localparam logic [GAIN_W-1:0] KD_RESET     = 24'd0;
  localparam logic [LIM_W-1:0]  ERR_MAX_RESET = 31'd3276800;
  localparam logic [LIM_W-1:0]  SEP_RESET    = 31'd6553600;
  localparam logic [LIM_W-1:0]  INT_MAX_RESET = 31'd655360;
  localparam logic [LIM_W-1:0]  OUT_LIM_RESET = 31'd131072;
  localparam logic [MODE_W-1:0] MODE_RESET   = 3'd0;

  // saturation bounds of a 32 bit signed value
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN       = 3'd0,
    REG_KI_GAIN       = 3'd1,
    REG_KD_GAIN       = 3'd2,
    REG_ERR_MAX       = 3'd3,
    REG_SEP_THRESHOLD = 3'd4,
    REG_INTEG_MAX     = 3'd5,
    REG_OUT_LIMIT     = 3'd6,
    REG_MODE_FLAGS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [LIM_W-1:0]  err_max;
    logic [LIM_W-1:0]  sep_threshold;
    logic [LIM_W-1:0]  integ_max;
    logic [LIM_W-1:0]  out_limit;
    logic [MODE_W-1:0] mode_flags;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prev_error;
    logic signed [DATA_W-1:0] integral_acc;
  } pid_state_t;

  // symmetric clamp of a 32 bit signed value to +-lim
  function automatic logic signed [DATA_W-1:0] clamp_sym32(
    input logic signed [DATA_W-1:0] x,
    input logic [LIM_W-1:0]         lim
  );
    logic signed [DATA_W-1:0] lim_s;
    logic signed [DATA_W-1:0] r;
    lim_s = $signed({1'b0, lim});
    if (x >= lim_s) begin
      r = lim_s;
    end else if (x <= -lim_s) begin
      r = -lim_s;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

### sv/ppid_stream_if.sv
// ----------------------------------------------------------------------------
// ppid_stream_if
// Valid/ready channels of the PID controller: sample in, result out.
// ----------------------------------------------------------------------------
interface ppid_in_if;
  import ppid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface ppid_out_if;
  import ppid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive_out;
  logic signed [DATA_W-1:0] error_out;

  modport source (output valid, output drive_out, output error_out, input ready);
  modport sink   (input valid, input drive_out, input error_out, output ready);
endinterface

### sv/positional_pid_controller_core.sv
// ----------------------------------------------------------------------------
// positional_pid_controller_core
// Positional PID controller in signed Q16.16 with optional error clamp,
// integral separation and integral clamp. Each sample transaction yields one
// result transaction carrying the clamped drive and the (clamped) error.
// A sample is registered, the whole step is computed in one pass of logic
// and the result is registered, so one sample is taken every clock cycle
// while the result side is not stalled; the rate is set by the loop
// through the integral and previous-error registers.
// Configuration writes take effect on the next cycle and belong between
// transactions, when no sample is in flight.
// ----------------------------------------------------------------------------
`include "positional_pid_controller_core_defines.svh"

module positional_pid_controller_core (
  input  logic                            clk,
  input  logic                            rst,
  ppid_in_if.sink                         sample,
  ppid_out_if.source                      result,
  input  logic                            cfg_we,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppid_pkg::*;

  cfg_t                     cfg;
  pid_state_t               state;
  pid_state_t               state_next;
  logic                     sample_valid;
  logic signed [DATA_W-1:0] sample_sp;
  logic signed [DATA_W-1:0] sample_fb;
  logic                     result_valid;
  logic signed [DATA_W-1:0] result_drive;
  logic signed [DATA_W-1:0] result_err;
  logic signed [DATA_W-1:0] drive_calc;
  logic signed [DATA_W-1:0] err_calc;
  logic                     advance;
  logic signed [DATA_W-1:0] int_lim;
  logic signed [DATA_W-1:0] out_lim;

  // configuration registers
  ppid_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: the input stage moves on when the result register is free
  assign advance      = sample_valid && (!result_valid || result.ready);
  assign sample.ready = !sample_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample.ready) begin
      sample_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      sample_sp <= sample.setpoint;
      sample_fb <= sample.measured;
    end
  end

  // single-pass step
  ppid_datapath u_dp (
    .setpoint   (sample_sp),
    .measured   (sample_fb),
    .cfg        (cfg),
    .state      (state),
    .drive_out  (drive_calc),
    .error_out  (err_calc),
    .state_next (state_next)
  );

  // controller state, updated once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_drive <= drive_calc;
      result_err   <= err_calc;
    end
  end

  assign result.valid     = result_valid;
  assign result.drive_out = result_drive;
  assign result.error_out = result_err;

  // limits as signed values for the checks below
  assign int_lim = $signed({1'b0, cfg.integ_max});
  assign out_lim = $signed({1'b0, cfg.out_limit});

  `PPID_ASSERT_NXT(a_result_loaded, clk, rst, advance, result.valid,
                   "result not valid after a step")
  `PPID_ASSERT_NXT(a_prev_tracks_err, clk, rst, advance,
                   state.prev_error == result.error_out,
                   "previous error differs from the delivered error")
  `PPID_ASSERT_NXT(a_int_clamp, clk, rst, advance && cfg.mode_flags[MODE_INT_CLAMP],
                   (state.integral_acc <= $past(int_lim)) && (state.integral_acc >= -$past(int_lim)),
                   "integral outside its clamp")
  `PPID_ASSERT_NXT(a_out_clamp, clk, rst, advance,
                   (result.drive_out <= $past(out_lim)) && (result.drive_out >= -$past(out_lim)),
                   "drive outside the output limit")
  `PPID_ASSERT_IMP(a_ready_when_empty, clk, rst, !result.valid, sample.ready,
                   "sample stalled while the result register is empty")

endmodule

### sv/ppid_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppid_cfg_regs
// Configuration register file: gains, limits and mode flags, write only.
// ----------------------------------------------------------------------------
module ppid_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppid_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ppid_pkg::cfg_t                      cfg
);
  import ppid_pkg::*;

  cfg_t cfg_next;

  // decode a register write, keeping only the register's low bits
  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_KP_GAIN:       cfg_next.kp_gain       = cfg_data[GAIN_W-1:0];
        REG_KI_GAIN:       cfg_next.ki_gain       = cfg_data[GAIN_W-1:0];
        REG_KD_GAIN:       cfg_next.kd_gain       = cfg_data[GAIN_W-1:0];
        REG_ERR_MAX:       cfg_next.err_max       = cfg_data[LIM_W-1:0];
        REG_SEP_THRESHOLD: cfg_next.sep_threshold = cfg_data[LIM_W-1:0];
        REG_INTEG_MAX:     cfg_next.integ_max     = cfg_data[LIM_W-1:0];
        REG_OUT_LIMIT:     cfg_next.out_limit     = cfg_data[LIM_W-1:0];
        REG_MODE_FLAGS:    cfg_next.mode_flags    = cfg_data[MODE_W-1:0];
        default:           cfg_next = cfg;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain       <= KP_RESET;
      cfg.ki_gain       <= KI_RESET;
      cfg.kd_gain       <= KD_RESET;
      cfg.err_max       <= ERR_MAX_RESET;
      cfg.sep_threshold <= SEP_RESET;
      cfg.integ_max     <= INT_MAX_RESET;
      cfg.out_limit     <= OUT_LIM_RESET;
      cfg.mode_flags    <= MODE_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

### sv/ppid_datapath.sv
// ----------------------------------------------------------------------------
// ppid_datapath
// One PID step in combinational logic: error, integral update and output.
// ----------------------------------------------------------------------------
module ppid_datapath (
  input  logic signed [ppid_pkg::DATA_W-1:0] setpoint,
  input  logic signed [ppid_pkg::DATA_W-1:0] measured,
  input  ppid_pkg::cfg_t                     cfg,
  input  ppid_pkg::pid_state_t               state,
  output logic signed [ppid_pkg::DATA_W-1:0] drive_out,
  output logic signed [ppid_pkg::DATA_W-1:0] error_out,
  output ppid_pkg::pid_state_t               state_next
);
  import ppid_pkg::*;

  logic signed [32:0] diff;
  logic signed [31:0] err_sat;
  logic signed [31:0] err;
  logic signed [32:0] err_abs;
  logic               sep_block;
  logic signed [56:0] prod_i;
  logic signed [41:0] isum;
  logic signed [31:0] integ_sat;
  logic signed [31:0] integ_add;
  logic signed [31:0] integ_new;
  logic signed [56:0] prod_p;
  logic signed [32:0] derr;
  logic signed [57:0] prod_d;
  logic signed [43:0] ysum;
  logic signed [43:0] ylim;
  logic signed [43:0] yclamp;

  // error: saturated difference, optional symmetric clamp
  always_comb begin
    diff = 33'(setpoint) - 33'(measured);
    if (diff[32] != diff[31]) begin
      err_sat = diff[32] ? S32_MIN : S32_MAX;
    end else begin
      err_sat = diff[31:0];
    end
    err = cfg.mode_flags[MODE_ERR_CLAMP] ? clamp_sym32(err_sat, cfg.err_max) : err_sat;
  end

  // integral: separation test, gain product, saturating add, optional clamp
  always_comb begin
    err_abs   = err[31] ? -33'(err) : 33'(err);
    sep_block = cfg.mode_flags[MODE_SEP] && (err_abs > $signed({2'b00, cfg.sep_threshold}));
    prod_i    = $signed({1'b0, cfg.ki_gain}) * err;
    isum      = 42'($signed(prod_i[56:16])) + 42'(state.integral_acc);
    if (isum > 42'(S32_MAX)) begin
      integ_sat = S32_MAX;
    end else if (isum < 42'(S32_MIN)) begin
      integ_sat = S32_MIN;
    end else begin
      integ_sat = isum[31:0];
    end
    integ_add = sep_block ? state.integral_acc : integ_sat;
    integ_new = cfg.mode_flags[MODE_INT_CLAMP] ? clamp_sym32(integ_add, cfg.integ_max)
                                               : integ_add;
  end

  // output: p + i + d terms summed exactly, then clamped to the limit
  always_comb begin
    prod_p = $signed({1'b0, cfg.kp_gain}) * err;
    derr   = 33'(err) - 33'(state.prev_error);
    prod_d = $signed({1'b0, cfg.kd_gain}) * derr;
    ysum   = 44'($signed(prod_p[56:16])) + 44'(integ_new) + 44'($signed(prod_d[57:16]));
    ylim   = 44'($signed({1'b0, cfg.out_limit}));
    if (ysum >= ylim) begin
      yclamp = ylim;
    end else if (ysum <= -ylim) begin
      yclamp = -ylim;
    end else begin
      yclamp = ysum;
    end
  end

  assign drive_out               = yclamp[31:0];
  assign error_out               = err;
  assign state_next.prev_error   = err;
  assign state_next.integral_acc = integ_new;

endmodule
